FILE: hdl/assert_macros.svh
// Assertion macros included by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

FILE: hdl/mslcg_pkg.sv
// Shared types, constants and function of the minimal standard generator.
`default_nettype none
package mslcg_pkg;

	localparam int unsigned STATE_W  = 31;
	localparam int unsigned DATA_W   = 32;
	localparam int unsigned MULT_W   = 15;
	localparam int unsigned PROD_W   = STATE_W + MULT_W;
	localparam int unsigned SPAN_W   = DATA_W + 1;
	localparam int unsigned DIV_STEPS = STATE_W;
	localparam int unsigned CNT_W    = $clog2(DIV_STEPS);
	localparam int unsigned Q_DEPTH  = 2;
	localparam int unsigned Q_PTR_W  = $clog2(Q_DEPTH);
	localparam int unsigned Q_CNT_W  = $clog2(Q_DEPTH + 1);

	localparam logic [STATE_W-1:0] LCG_MOD    = 31'h7FFF_FFFF;
	localparam logic [MULT_W-1:0]  LCG_MULT   = 15'd16807;
	localparam logic [STATE_W-1:0] RESET_SEED = 31'd314159;
	localparam logic [STATE_W-1:0] SAFE_SEED  = 31'd1;

	typedef enum logic {
		CMD_RAW    = 1'b0,
		CMD_RANGED = 1'b1
	} cmd_t;

	typedef struct packed {
		cmd_t              cmd;
		logic              err;
		logic [DATA_W-1:0] lo;
		logic [DATA_W-1:0] span;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	function automatic logic [STATE_W-1:0] legal_state(input logic [STATE_W-1:0] v);
		logic [STATE_W-1:0] r;
		r = v;
		if (v == '0 || v == LCG_MOD) begin
			r = SAFE_SEED;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: hdl/mslcg_front.sv
// Front end: accepts requests, forms the range span and flags empty ranges.
`default_nettype none
module mslcg_front (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [2*mslcg_pkg::DATA_W-1:0] s_tdata,
	input  wire logic                           s_tuser,
	input  wire mslcg_pkg::q_status_t           q_stat,
	output logic                                push,
	output mslcg_pkg::job_t                     push_job
);

	logic                              valid_s1;
	mslcg_pkg::job_t                   job_s1;
	logic [mslcg_pkg::DATA_W-1:0]      lo;
	logic [mslcg_pkg::DATA_W-1:0]      hi;
	logic [mslcg_pkg::SPAN_W-1:0]      span;
	logic                              take;

	assign lo   = s_tdata[mslcg_pkg::DATA_W-1:0];
	assign hi   = s_tdata[2*mslcg_pkg::DATA_W-1:mslcg_pkg::DATA_W];
	assign span = {hi[mslcg_pkg::DATA_W-1], hi} - {lo[mslcg_pkg::DATA_W-1], lo};

	assign s_tready = !valid_s1 || !q_stat.full;
	assign take     = s_tvalid && s_tready;
	assign push     = valid_s1 && !q_stat.full;
	assign push_job = job_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			job_s1.cmd  <= mslcg_pkg::cmd_t'(s_tuser);
			job_s1.err  <= span[mslcg_pkg::SPAN_W-1] || (span == '0);
			job_s1.lo   <= lo;
			job_s1.span <= span[mslcg_pkg::DATA_W-1:0];
		end
	end

endmodule
`default_nettype wire

FILE: hdl/mslcg_queue.sv
// Short job queue between the front end and the generator back end.
`default_nettype none
module mslcg_queue (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire mslcg_pkg::job_t       push_job,
	input  wire logic                  pop,
	output mslcg_pkg::job_t            head_job,
	output mslcg_pkg::q_status_t       q_stat
);

	mslcg_pkg::job_t                 entries_q [mslcg_pkg::Q_DEPTH];
	logic [mslcg_pkg::Q_PTR_W-1:0]   wr_ptr_q;
	logic [mslcg_pkg::Q_PTR_W-1:0]   rd_ptr_q;
	logic [mslcg_pkg::Q_CNT_W-1:0]   count_q;

	assign q_stat.full  = (count_q == mslcg_pkg::Q_CNT_W'(mslcg_pkg::Q_DEPTH));
	assign q_stat.empty = (count_q == '0);
	assign head_job     = entries_q[rd_ptr_q];

	function automatic logic [mslcg_pkg::Q_PTR_W-1:0] next_ptr(
		input logic [mslcg_pkg::Q_PTR_W-1:0] p);
		logic [mslcg_pkg::Q_PTR_W-1:0] n;
		n = p + 1'b1;
		if (p == mslcg_pkg::Q_PTR_W'(mslcg_pkg::Q_DEPTH - 1)) begin
			n = '0;
		end
		return n;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_job;
		end
	end

endmodule
`default_nettype wire

FILE: hdl/mslcg_back.sv
// Back end: advances the generator, reduces into range and holds the result.
`default_nettype none
module mslcg_back (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            seed_wr_en,
	input  wire logic [mslcg_pkg::STATE_W-1:0]   seed_wr_data,
	input  wire mslcg_pkg::q_status_t            q_stat,
	input  wire mslcg_pkg::job_t                 head_job,
	output logic                                 pop,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic [mslcg_pkg::DATA_W-1:0]         m_tdata,
	output logic                                 m_tuser,
	output logic [mslcg_pkg::STATE_W-1:0]        gen_state
);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_MUL  = 6'b000010,
		ST_MOD  = 6'b000100,
		ST_DIV  = 6'b001000,
		ST_ADD  = 6'b010000,
		ST_OUT  = 6'b100000
	} st_t;

	st_t                                st_q;
	mslcg_pkg::job_t                    job_q;
	logic [mslcg_pkg::STATE_W-1:0]      state_q;
	logic [mslcg_pkg::PROD_W-1:0]       prod_q;
	logic [mslcg_pkg::DATA_W-1:0]       rem_q;
	logic [mslcg_pkg::STATE_W-1:0]      dvd_q;
	logic [mslcg_pkg::CNT_W-1:0]        cnt_q;
	logic [mslcg_pkg::DATA_W-1:0]       val_q;
	logic                               err_q;
	logic [mslcg_pkg::DATA_W-1:0]       fold;
	logic [mslcg_pkg::STATE_W-1:0]      reduced;
	logic [mslcg_pkg::SPAN_W-1:0]       trial;
	logic [mslcg_pkg::SPAN_W-1:0]       diff;

	assign pop       = (st_q == ST_IDLE) && !q_stat.empty;
	assign m_tvalid  = (st_q == ST_OUT);
	assign m_tdata   = val_q;
	assign m_tuser   = err_q;
	assign gen_state = state_q;

	assign fold = {1'b0, prod_q[mslcg_pkg::STATE_W-1:0]}
		+ mslcg_pkg::DATA_W'(prod_q[mslcg_pkg::PROD_W-1:mslcg_pkg::STATE_W]);
	assign reduced = (fold >= {1'b0, mslcg_pkg::LCG_MOD})
		? mslcg_pkg::STATE_W'(fold - {1'b0, mslcg_pkg::LCG_MOD})
		: fold[mslcg_pkg::STATE_W-1:0];

	assign trial = {rem_q, dvd_q[mslcg_pkg::STATE_W-1]};
	assign diff  = trial - {1'b0, job_q.span};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			state_q <= mslcg_pkg::RESET_SEED;
			cnt_q   <= '0;
		end else begin
			if (seed_wr_en) begin
				state_q <= mslcg_pkg::legal_state(seed_wr_data);
			end else if (st_q == ST_MOD) begin
				state_q <= reduced;
			end
			case (st_q)
				ST_IDLE: begin
					if (pop) begin
						st_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					st_q <= ST_MOD;
				end
				ST_MOD: begin
					cnt_q <= '0;
					if (job_q.cmd == mslcg_pkg::CMD_RAW || job_q.err) begin
						st_q <= ST_OUT;
					end else begin
						st_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == mslcg_pkg::CNT_W'(mslcg_pkg::DIV_STEPS - 1)) begin
						st_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					st_q <= ST_OUT;
				end
				ST_OUT: begin
					if (m_tready) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				if (pop) begin
					job_q <= head_job;
				end
			end
			ST_MUL: begin
				prod_q <= state_q * mslcg_pkg::LCG_MULT;
			end
			ST_MOD: begin
				rem_q <= '0;
				dvd_q <= reduced;
				if (job_q.cmd == mslcg_pkg::CMD_RAW) begin
					val_q <= {1'b0, reduced};
					err_q <= 1'b0;
				end else begin
					val_q <= '0;
					err_q <= job_q.err;
				end
			end
			ST_DIV: begin
				dvd_q <= dvd_q << 1;
				if (!diff[mslcg_pkg::SPAN_W-1]) begin
					rem_q <= diff[mslcg_pkg::DATA_W-1:0];
				end else begin
					rem_q <= trial[mslcg_pkg::DATA_W-1:0];
				end
			end
			ST_ADD: begin
				val_q <= job_q.lo + rem_q;
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

FILE: hdl/minimal_standard_lcg_ranged.sv
// A request is registered in the front end and queued; the back end then multiplies, reduces modulo
// 2^31-1 and, for a valid ranged draw, adds lo to the state modulo the span, which is formed by the
// 31-step restoring divider. The back end takes a new job only after its result has transferred.
// A two-entry queue lets requests transfer while a result waits on the output.
// Reset: generator state loads 314159, queue and output are emptied.
`default_nettype none
`include "assert_macros.svh"
module minimal_standard_lcg_ranged (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           seed_wr_en,
	input  wire logic [mslcg_pkg::STATE_W-1:0]  seed_wr_data,
	input  wire logic                           s_axis_tvalid,
	output logic                                s_axis_tready,
	// range_low [31:0], range_high [63:32]
	input  wire logic [2*mslcg_pkg::DATA_W-1:0] s_axis_tdata,
	// command [0]
	input  wire logic                           s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  wire logic                           m_axis_tready,
	// value [31:0]
	output logic [mslcg_pkg::DATA_W-1:0]        m_axis_tdata,
	// range_error [0]
	output logic                                m_axis_tuser
);

	mslcg_pkg::q_status_t               q_stat;
	mslcg_pkg::job_t                    push_job;
	mslcg_pkg::job_t                    head_job;
	logic                               push;
	logic                               pop;
	logic [mslcg_pkg::STATE_W-1:0]      gen_state;

	mslcg_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_axis_tvalid),
		.s_tready (s_axis_tready),
		.s_tdata  (s_axis_tdata),
		.s_tuser  (s_axis_tuser),
		.q_stat   (q_stat),
		.push     (push),
		.push_job (push_job)
	);

	mslcg_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head_job (head_job),
		.q_stat   (q_stat)
	);

	mslcg_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.seed_wr_en   (seed_wr_en),
		.seed_wr_data (seed_wr_data),
		.q_stat       (q_stat),
		.head_job     (head_job),
		.pop          (pop),
		.m_tvalid     (m_axis_tvalid),
		.m_tready     (m_axis_tready),
		.m_tdata      (m_axis_tdata),
		.m_tuser      (m_axis_tuser),
		.gen_state    (gen_state)
	);

	`ASSERT_IMPLIES(a_err_value_zero, clk, arst_n, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0)
	`ASSERT_NEVER(a_queue_full_empty, clk, arst_n, q_stat.full && q_stat.empty)
	`ASSERT_NEVER(a_state_legal, clk, arst_n, gen_state == '0 || gen_state == mslcg_pkg::LCG_MOD)
	`ASSERT_NEVER(a_pop_empty, clk, arst_n, pop && q_stat.empty)

endmodule
`default_nettype wire
